// ===== src/wes_pkg.sv =====
// ----------------------------------------------------------------------------
// wes_pkg
// Shared types and constants for the Western Electric SPC monitor.
// ----------------------------------------------------------------------------
package wes_pkg;

    // Operations of the shared iterative unit
    typedef enum logic [1:0] {
        OP_DIV  = 2'd0,
        OP_MUL  = 2'd1,
        OP_SQRT = 2'd2
    } t_op;

    // Request from the sequencer to the iterative unit
    typedef struct packed {
        logic       start;
        t_op        op;
        logic [6:0] steps;
    } t_iter_req;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MDIV,
        ST_D2,
        ST_TMUL,
        ST_EMUL,
        ST_FRZ,
        ST_VDIV,
        ST_SQRT,
        ST_ZONE,
        ST_RULE,
        ST_OUT
    } t_state;

    // Configuration register indexes
    localparam logic [1:0] CFG_CENTER = 2'd0;
    localparam logic [1:0] CFG_WEIGHT = 2'd1;
    localparam logic [1:0] CFG_WARMUP = 2'd2;

    localparam logic [16:0] WEIGHT_DEFAULT = 17'd13107;
    localparam logic [16:0] WEIGHT_ONE     = 17'd65536;
    localparam logic [15:0] WARMUP_DEFAULT = 16'd25;
    localparam logic [15:0] WARMUP_MIN     = 16'd5;
    localparam logic [31:0] SIGMA_FLOOR    = 32'd256;

    // Rule codes
    localparam logic [2:0] RULE_NONE  = 3'd0;
    localparam logic [2:0] RULE_BEYOND3 = 3'd1;
    localparam logic [2:0] RULE_TWO3  = 3'd2;
    localparam logic [2:0] RULE_FOUR5 = 3'd3;
    localparam logic [2:0] RULE_RUN8  = 3'd4;

endpackage

// ===== src/western_electric_spc_monitor.sv =====
// ----------------------------------------------------------------------------
// western_electric_spc_monitor
// Control-chart monitor: Welford baseline, EWMA, frozen sigma, zone history
// and Western Electric rules 1 to 4 with alarm bookkeeping.
// ----------------------------------------------------------------------------
// Flow: each sample runs the mean divide, the squared-deviation multiply and,
//   once the EWMA has begun, the EWMA multiply; the sample that freezes sigma
//   adds a 64-step variance divide plus 32-step square root before result valid.
// Throughput: one sample at a time; the 64-step mean divide on the shared
//   iterative unit dominates each sample.
// Reset: synchronous, active low; all statistics, history and alarm state
//   clear, registers return to center 0, lambda 13107, warmup 25.
module western_electric_spc_monitor #(
    parameter int HISTORY_DEPTH = 8,
    parameter int SAMPLE_BITS   = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [INW-1:0]         i_s_axis_tdata,   // [SAMPLE_BITS-1:0] sample
    // result stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [103:0]           o_m_axis_tdata,   // [2:0] rule_hit,
                                                     // [34:3] ewma_value,
                                                     // [35] baseline_frozen,
                                                     // [67:36] alarm_total,
                                                     // [70:68] first_alarm_rule,
                                                     // [102:71] first_alarm_index
    // configuration
    input  logic                   i_cfg_wr_en,
    input  logic [1:0]             i_cfg_index,
    input  logic [16:0]            i_cfg_wdata
);
    localparam int INW = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int XW  = SAMPLE_BITS + 16;            // scaled sample, mean, ewma
    localparam int DW  = SAMPLE_BITS + 17;            // deviations
    localparam int PW  = 2 * SAMPLE_BITS + 34;        // deviation product
    localparam int UW  = (PW > 66) ? PW : 66;         // iterative unit width
    localparam int TW  = PW - 16;                     // squared-deviation term
    localparam int SW  = ((TW > 64) ? TW : 64) + 1;   // saturating sum width
    localparam int EVW = DW + 18;                     // signed ewma product
    localparam int CW  = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 1;
    localparam int AW  = ((CW + 8) > 34) ? (CW + 8) : 34;
    localparam int FW  = $clog2(HISTORY_DEPTH + 1);
    localparam logic [6:0] DIV_STEPS = 7'd64;
    localparam logic [6:0] SQRT_STEPS = 7'd32;
    localparam logic [6:0] EMUL_STEPS = 7'd17;

    // configuration registers
    logic signed [15:0] r_center;
    logic [16:0]        r_weight;
    logic [15:0]        r_warmup;

    // statistics state
    wes_pkg::t_state           r_state, n_state;
    logic signed [SAMPLE_BITS-1:0] r_smp;
    logic [31:0]               r_total;
    logic signed [XW-1:0]      r_mean;
    logic [63:0]               r_sumsq;
    logic signed [XW-1:0]      r_ewma;
    logic                      r_ewma_begun;
    logic [31:0]               r_sigma;
    logic                      r_frozen;
    logic                      r_dneg;
    logic [DW-1:0]             r_ad;
    logic                      r_eneg;

    // zone history, newest at index 0
    logic                      r_side  [HISTORY_DEPTH];
    logic [1:0]                r_level [HISTORY_DEPTH];
    logic [FW-1:0]             r_fill;

    // alarm bookkeeping and current result
    logic [31:0]               r_alarms;
    logic [2:0]                r_first_rule;
    logic [31:0]               r_first_idx;
    logic [2:0]                r_rule;

    // iterative unit
    wes_pkg::t_iter_req        req;
    logic [UW-1:0]             arg_a, arg_b, u_res;
    logic                      u_done;

    wes_iter_unit #(.SAMPLE_BITS(SAMPLE_BITS)) u_iter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (req),
        .i_arg_a  (arg_a),
        .i_arg_b  (arg_b),
        .o_done   (u_done),
        .o_result (u_res)
    );

    // ------------------------------------------------------------------
    // datapath terms
    // ------------------------------------------------------------------
    logic signed [DW-1:0]  xs, d, d2, ed;
    logic [DW-1:0]         ad2, aed;
    logic [DW-1:0]         qmag;
    logic signed [DW-1:0]  mean_new;
    logic [TW-1:0]         term;
    logic [SW-1:0]         sum_ext;
    logic signed [EVW-1:0] evp, evr;
    logic signed [XW-1:0]  ewma_new;
    logic signed [CW-1:0]  zdiff;
    logic [CW-1:0]         zmag;
    logic [AW-1:0]         za, s1, s2, s3;
    logic [1:0]            zlevel;
    logic [31:0]           n_m1;

    always_comb begin
        xs   = DW'(r_smp) <<< 16;
        d    = xs - DW'(r_mean);
        d2   = xs - DW'(r_mean);
        ad2  = d2[DW-1] ? DW'(-d2) : DW'(d2);
        ed   = xs - DW'(r_ewma);
        aed  = ed[DW-1] ? DW'(-ed) : DW'(ed);
        qmag = u_res[DW-1:0];
        mean_new = DW'(r_mean) + (r_dneg ? -$signed(qmag) : $signed(qmag));
        term = u_res[PW-1:16];
        sum_ext = SW'(r_sumsq) + SW'(term);
        evp  = $signed({1'b0, u_res[EVW-2:0]});
        evr  = ((r_eneg ? -evp : evp) + EVW'(32768)) >>> 16;
        ewma_new = XW'(EVW'(r_ewma) + evr);
        zdiff = CW'(r_smp) - CW'(r_center);
        zmag  = zdiff[CW-1] ? CW'(-zdiff) : CW'(zdiff);
        za    = AW'({zmag, 8'b0});
        s1    = AW'(r_sigma);
        s2    = AW'({r_sigma, 1'b0});
        s3    = s2 + s1;
        if (za > s3)      zlevel = 2'd3;
        else if (za > s2) zlevel = 2'd2;
        else if (za > s1) zlevel = 2'd1;
        else              zlevel = 2'd0;
        n_m1 = r_total - 32'd1;
    end

    // ------------------------------------------------------------------
    // rule check on the history after the push (Western Electric 1..4)
    // ------------------------------------------------------------------
    logic [2:0] rule_now;
    logic [1:0] cnt3;
    logic [2:0] cnt5;
    logic [3:0] cnt8;

    always_comb begin
        cnt3 = '0;
        cnt5 = '0;
        cnt8 = '0;
        for (int j = 0; j < 3; j++)
            if (FW'(j) < r_fill && r_side[j] == r_side[0] && r_level[j] >= 2'd2)
                cnt3 = cnt3 + 2'd1;
        for (int j = 0; j < 5; j++)
            if (FW'(j) < r_fill && r_side[j] == r_side[0] && r_level[j] >= 2'd1)
                cnt5 = cnt5 + 3'd1;
        for (int j = 0; j < 8; j++)
            if (FW'(j) < r_fill && r_side[j] == r_side[0])
                cnt8 = cnt8 + 4'd1;
        priority if (r_level[0] == 2'd3)
            rule_now = wes_pkg::RULE_BEYOND3;
        else if (r_level[0] >= 2'd2 && r_fill >= FW'(2) && cnt3 >= 2'd2)
            rule_now = wes_pkg::RULE_TWO3;
        else if (r_level[0] >= 2'd1 && r_fill >= FW'(4) && cnt5 >= 3'd4)
            rule_now = wes_pkg::RULE_FOUR5;
        else if (r_fill >= FW'(8) && cnt8 == 4'd8)
            rule_now = wes_pkg::RULE_RUN8;
        else
            rule_now = wes_pkg::RULE_NONE;
    end

    // ------------------------------------------------------------------
    // sequencer: next state and unit requests
    // ------------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        req.start = 1'b0;
        req.op    = wes_pkg::OP_MUL;
        req.steps = DIV_STEPS;
        arg_a     = '0;
        arg_b     = '0;
        unique case (r_state)
            wes_pkg::ST_IDLE:
                if (i_s_axis_tvalid) n_state = wes_pkg::ST_DIFF;
            wes_pkg::ST_DIFF: begin
                // mean step: (|d| + n/2) / n, rounded half away from zero
                req.start = 1'b1;
                req.op    = wes_pkg::OP_DIV;
                req.steps = DIV_STEPS;
                arg_a     = UW'(64'(d[DW-1] ? DW'(-d) : DW'(d)) + 64'(r_total[31:1]));
                arg_b     = UW'(r_total);
                n_state   = wes_pkg::ST_MDIV;
            end
            wes_pkg::ST_MDIV:
                if (u_done) n_state = wes_pkg::ST_D2;
            wes_pkg::ST_D2: begin
                req.start = 1'b1;
                req.op    = wes_pkg::OP_MUL;
                req.steps = 7'(DW);
                arg_a     = UW'(r_ad);
                arg_b     = UW'(ad2);
                n_state   = wes_pkg::ST_TMUL;
            end
            wes_pkg::ST_TMUL:
                if (u_done) begin
                    if (r_ewma_begun) begin
                        // ewma += floor((lambda*(x-e) + 32768) / 65536)
                        req.start = 1'b1;
                        req.op    = wes_pkg::OP_MUL;
                        req.steps = EMUL_STEPS;
                        arg_a     = UW'(aed);
                        arg_b     = UW'(r_weight);
                        n_state   = wes_pkg::ST_EMUL;
                    end else begin
                        n_state   = wes_pkg::ST_FRZ;
                    end
                end
            wes_pkg::ST_EMUL:
                if (u_done) n_state = wes_pkg::ST_FRZ;
            wes_pkg::ST_FRZ:
                if (r_frozen) begin
                    n_state = wes_pkg::ST_ZONE;
                end else if (r_total >= 32'(r_warmup)) begin
                    // warmup is at least 5, so n - 1 is never zero here
                    req.start = 1'b1;
                    req.op    = wes_pkg::OP_DIV;
                    req.steps = DIV_STEPS;
                    arg_a     = UW'(r_sumsq);
                    arg_b     = UW'(n_m1);
                    n_state   = wes_pkg::ST_VDIV;
                end else begin
                    n_state = wes_pkg::ST_OUT;
                end
            wes_pkg::ST_VDIV:
                if (u_done) begin
                    req.start = 1'b1;
                    req.op    = wes_pkg::OP_SQRT;
                    req.steps = SQRT_STEPS;
                    arg_a     = UW'(u_res[63:0]);
                    n_state   = wes_pkg::ST_SQRT;
                end
            wes_pkg::ST_SQRT:
                if (u_done) n_state = wes_pkg::ST_OUT;
            wes_pkg::ST_ZONE:
                n_state = wes_pkg::ST_RULE;
            wes_pkg::ST_RULE:
                n_state = wes_pkg::ST_OUT;
            wes_pkg::ST_OUT:
                if (i_m_axis_tready) n_state = wes_pkg::ST_IDLE;
            default:
                n_state = wes_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= wes_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= '0;
            r_weight <= wes_pkg::WEIGHT_DEFAULT;
            r_warmup <= wes_pkg::WARMUP_DEFAULT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                wes_pkg::CFG_CENTER: r_center <= $signed(i_cfg_wdata[15:0]);
                wes_pkg::CFG_WEIGHT:
                    r_weight <= (i_cfg_wdata == '0 || i_cfg_wdata > wes_pkg::WEIGHT_ONE)
                                ? wes_pkg::WEIGHT_DEFAULT : i_cfg_wdata;
                wes_pkg::CFG_WARMUP:
                    r_warmup <= (i_cfg_wdata[15:0] < wes_pkg::WARMUP_MIN)
                                ? wes_pkg::WARMUP_MIN : i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // statistics datapath
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp        <= '0;
            r_total      <= '0;
            r_mean       <= '0;
            r_sumsq      <= '0;
            r_ewma       <= '0;
            r_ewma_begun <= 1'b0;
            r_sigma      <= '0;
            r_frozen     <= 1'b0;
            r_dneg       <= 1'b0;
            r_ad         <= '0;
            r_eneg       <= 1'b0;
            r_fill       <= '0;
            r_alarms     <= '0;
            r_first_rule <= wes_pkg::RULE_NONE;
            r_first_idx  <= '0;
            r_rule       <= wes_pkg::RULE_NONE;
            for (int k = 0; k < HISTORY_DEPTH; k++) begin
                r_side[k]  <= 1'b0;
                r_level[k] <= 2'd0;
            end
        end else begin
            unique case (r_state)
                wes_pkg::ST_IDLE:
                    if (i_s_axis_tvalid) begin
                        r_smp  <= $signed(i_s_axis_tdata[SAMPLE_BITS-1:0]);
                        r_rule <= wes_pkg::RULE_NONE;
                        if (r_total != '1) r_total <= r_total + 32'd1;
                    end
                wes_pkg::ST_DIFF: begin
                    r_dneg <= d[DW-1];
                    r_ad   <= d[DW-1] ? DW'(-d) : DW'(d);
                end
                wes_pkg::ST_MDIV:
                    if (u_done) r_mean <= XW'(mean_new);
                wes_pkg::ST_TMUL:
                    if (u_done) begin
                        r_sumsq <= (sum_ext > SW'(64'hFFFF_FFFF_FFFF_FFFF))
                                   ? '1 : sum_ext[63:0];
                        r_eneg  <= ed[DW-1];
                        if (!r_ewma_begun) begin
                            r_ewma       <= XW'(xs);
                            r_ewma_begun <= 1'b1;
                        end
                    end
                wes_pkg::ST_EMUL:
                    if (u_done) r_ewma <= ewma_new;
                wes_pkg::ST_SQRT:
                    if (u_done) begin
                        r_sigma  <= (u_res[31:0] < wes_pkg::SIGMA_FLOOR)
                                    ? wes_pkg::SIGMA_FLOOR : u_res[31:0];
                        r_frozen <= 1'b1;
                    end
                wes_pkg::ST_ZONE: begin
                    r_side[0]  <= ~zdiff[CW-1];
                    r_level[0] <= zlevel;
                    for (int k = 1; k < HISTORY_DEPTH; k++) begin
                        r_side[k]  <= r_side[k-1];
                        r_level[k] <= r_level[k-1];
                    end
                    if (r_fill != FW'(HISTORY_DEPTH)) r_fill <= r_fill + FW'(1);
                end
                wes_pkg::ST_RULE: begin
                    r_rule <= rule_now;
                    if (rule_now != wes_pkg::RULE_NONE) begin
                        if (r_alarms != '1) r_alarms <= r_alarms + 32'd1;
                        if (r_first_rule == wes_pkg::RULE_NONE) begin
                            r_first_rule <= rule_now;
                            r_first_idx  <= r_total;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // ports
    // ------------------------------------------------------------------
    logic signed [XW+31:0] ewma_ext;
    assign ewma_ext = {{32{r_ewma[XW-1]}}, r_ewma};

    assign o_s_axis_tready = (r_state == wes_pkg::ST_IDLE);
    assign o_m_axis_tvalid = (r_state == wes_pkg::ST_OUT);
    assign o_m_axis_tdata  = {1'b0, r_first_idx, r_first_rule, r_alarms, r_frozen,
                              ewma_ext[31:0], r_rule};

endmodule

// ===== src/wes_iter_unit.sv =====
// ----------------------------------------------------------------------------
// wes_iter_unit
// Shared iterative unit: restoring divide, shift-add multiply and integer
// square root, one step per cycle on a single adder/subtractor.
// ----------------------------------------------------------------------------
module wes_iter_unit #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  wes_pkg::t_iter_req    i_req,
    input  logic [UW-1:0]         i_arg_a,   // dividend / multiplicand / radicand
    input  logic [UW-1:0]         i_arg_b,   // divisor / multiplier
    output logic                  o_done,
    output logic [UW-1:0]         o_result
);
    localparam int PW = 2 * SAMPLE_BITS + 34;
    localparam int UW = (PW > 66) ? PW : 66;

    logic [UW-1:0] r_acc, r_x, r_y, r_q;
    logic [6:0]    r_cnt;
    logic          r_busy, r_done;
    wes_pkg::t_op  r_op;

    logic [UW-1:0] opx, opy, rem_div, rem_sqr, trial;
    logic          sub;
    logic [UW:0]   sum;
    logic          no_borrow;

    always_comb begin
        rem_div = {r_acc[UW-2:0], r_x[63]};
        rem_sqr = {r_acc[UW-3:0], r_x[63:62]};
        trial   = {r_q[UW-3:0], 2'b01};
        unique case (r_op)
            wes_pkg::OP_DIV: begin
                opx = rem_div; opy = r_y; sub = 1'b1;
            end
            wes_pkg::OP_SQRT: begin
                opx = rem_sqr; opy = trial; sub = 1'b1;
            end
            default: begin
                opx = r_acc; opy = r_x; sub = 1'b0;
            end
        endcase
        sum = {1'b0, opx} + {1'b0, (sub ? ~opy : opy)} + (UW+1)'(sub);
        no_borrow = sum[UW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= wes_pkg::OP_MUL;
            r_acc  <= '0;
            r_x    <= '0;
            r_y    <= '0;
            r_q    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_cnt  <= i_req.steps;
                r_acc  <= '0;
                r_q    <= '0;
                r_x    <= i_arg_a;
                r_y    <= i_arg_b;
            end else if (r_busy) begin
                unique case (r_op)
                    wes_pkg::OP_DIV: begin
                        r_acc <= no_borrow ? sum[UW-1:0] : rem_div;
                        r_q   <= {r_q[UW-2:0], no_borrow};
                        r_x   <= {r_x[UW-2:0], 1'b0};
                    end
                    wes_pkg::OP_SQRT: begin
                        r_acc <= no_borrow ? sum[UW-1:0] : rem_sqr;
                        r_q   <= {r_q[UW-2:0], no_borrow};
                        r_x   <= {r_x[UW-3:0], 2'b00};
                    end
                    default: begin
                        if (r_y[0]) r_acc <= sum[UW-1:0];
                        r_x <= {r_x[UW-2:0], 1'b0};
                        r_y <= {1'b0, r_y[UW-1:1]};
                    end
                endcase
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = (r_op == wes_pkg::OP_MUL) ? r_acc : r_q;

endmodule
